// File: design/assert_macros.svh
// assertion helpers shared by the rtl, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define FDMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define FDMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FDMA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/fdma_pkg.sv
`default_nettype none
package fdma_pkg;

  localparam int FRAME_PIXELS_DEF = 76800;

  localparam int PIX_W      = 8;
  localparam int IDX_W      = 17;
  localparam int GAIN_W     = 12;
  localparam int DECAY_W    = 17;
  localparam int LEVEL_W    = 24;
  localparam int SCALED_W   = PIX_W + GAIN_W;
  localparam int PROD_W     = LEVEL_W + DECAY_W;
  localparam int SUM_W      = LEVEL_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DAMP_SHIFT = 16;

  localparam logic [GAIN_W-1:0]  DIFF_GAIN_RST    = 12'd768;
  localparam logic [DECAY_W-1:0] DECAY_RST        = 17'd55706;
  localparam logic [LEVEL_W-1:0] MOTION_LEVEL_RST = 24'd58752;
  localparam logic [DECAY_W-1:0] DECAY_ONE        = 17'h10000;
  localparam logic [PROD_W-1:0]  DAMP_ROUND       = 41'd32768;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_GAIN    = 2'd0,
    CFG_DECAY_FACTOR = 2'd1,
    CFG_MOTION_LEVEL = 2'd2
  } cfg_reg_t;

  // frame count, saturating at later frames
  typedef enum logic [1:0] {
    PH_NONE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2,
    PH_LATER  = 2'd3
  } phase_t;

  // per-stage control tag
  typedef struct packed {
    logic vld;      // stage holds a beat
    logic wr;       // beat updates the accumulator and gives a ready result
    logic use_acc;  // beat damps the stored accumulator
  } stage_ctl_t;

endpackage
`default_nettype wire

// File: design/frame_diff_motion_accumulator_top.sv
// frame difference motion accumulator
// in_* channel: one grayscale pixel per beat with its raster index and a
// frame start flag; a beat is taken when in_valid is high and in_stall low.
// out_* channel: one result beat per input beat, in order (ready_res, motion,
// level); taken when out_valid is high and out_stall low.
// cfg_* channel: register writes (0 diff_gain, 1 decay_factor, 2 motion_level),
// always ready; write only while no pixel is in flight.
// throughput: one pixel per clock while the output is not stalled. the
// accumulator memory is read-modify-write over three stages; from the second
// frame on, a pixel with the index of the pixel just before it is held back by a
// bubble, so a raster stream never meets it. a pixel goes through stage 1, stage 2
// and the output register. when out_stall holds a result, the two inner stages
// still fill, so two more pixels are taken before in_stall rises.
// reset: frame count cleared and registers back to their defaults; the pixel
// and accumulator memories are not cleared, the first two frames fill them.
`default_nettype none
`include "assert_macros.svh"
module frame_diff_motion_accumulator_top import fdma_pkg::*; #(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pixel input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      in_gray_pixel,
  input  wire logic [IDX_W-1:0]      in_pixel_index,
  input  wire logic                  in_frame_start,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_ready_res,
  output logic                       out_motion,
  output logic      [LEVEL_W-1:0]    out_level,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int EXT_W  = IDX_W + ADDR_W + 1;

  // config registers
  logic [GAIN_W-1:0]   diff_gain_r;
  logic [DECAY_W-1:0]  decay_factor_r;
  logic [LEVEL_W-1:0]  motion_level_r;

  // frame count
  phase_t              frames_seen_r;
  phase_t              frames_nxt;

  // accept stage
  logic [EXT_W-1:0]    in_ext;
  logic                in_rng;
  logic [ADDR_W-1:0]   in_addr;
  logic                accept;
  logic                hazard;
  logic                adv;
  stage_ctl_t          in_ctl;

  // pipeline tags
  stage_ctl_t          s1_ctl_r;
  stage_ctl_t          s2_ctl_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [ADDR_W-1:0]   s2_addr_r;

  // datapath
  logic [SCALED_W-1:0] scaled;
  logic [LEVEL_W-1:0]  level;

  // output register
  logic                out_valid_r;
  logic                out_ready_res_r;
  logic                out_motion_r;
  logic [LEVEL_W-1:0]  out_level_r;
  logic                out_load;

  // check terms
  logic                upd_overlap;
  logic                out_blank;
  logic                out_zero;
  logic                out_ready_beat;
  logic                phase_ready;
  logic                count_open;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_gain_r    <= DIFF_GAIN_RST;
      decay_factor_r <= DECAY_RST;
      motion_level_r <= MOTION_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DIFF_GAIN:    diff_gain_r    <= cfg_data[GAIN_W-1:0];
        CFG_DECAY_FACTOR: decay_factor_r <= cfg_data[DECAY_W-1:0];
        CFG_MOTION_LEVEL: motion_level_r <= cfg_data[LEVEL_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // the whole pipe moves unless the output holds a result and stage 2 is full
  assign adv = !(out_valid_r && out_stall && s2_ctl_r.vld);

  // index range check and memory address
  assign in_ext  = EXT_W'(in_pixel_index);
  assign in_rng  = in_ext < EXT_W'(FRAME_PIXELS);
  assign in_addr = in_ext[ADDR_W-1:0];

  // same entry as the accumulator update one stage ahead: insert one bubble
  // so the write-back register can cover it
  assign hazard   = s1_ctl_r.vld && s1_ctl_r.wr && (in_addr == s1_addr_r);
  assign in_stall = !adv || hazard;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------- frame count
  always_comb begin
    frames_nxt = frames_seen_r;
    if (in_frame_start) begin
      case (frames_seen_r)
        PH_NONE:   frames_nxt = PH_FIRST;
        PH_FIRST:  frames_nxt = PH_SECOND;
        PH_SECOND: frames_nxt = PH_LATER;
        PH_LATER:  frames_nxt = PH_LATER;
        default:   frames_nxt = PH_LATER;
      endcase
    end else if (frames_seen_r == PH_NONE) begin
      // pixel without a start mark opens the first frame
      frames_nxt = PH_FIRST;
    end
  end

  // tag for the beat being accepted, phase taken after the count update
  always_comb begin
    in_ctl.vld     = accept;
    in_ctl.wr      = in_rng && ((frames_nxt == PH_SECOND) || (frames_nxt == PH_LATER));
    in_ctl.use_acc = frames_nxt == PH_LATER;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_seen_r <= PH_NONE;
    end else if (accept) begin
      frames_seen_r <= frames_nxt;
    end
  end

  // ---------------------------------------------------------------- pipe tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= in_ctl;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r <= in_addr;
      s2_addr_r <= s1_addr_r;
    end
  end

  // ---------------------------------------------------------------- stores
  // previous frame: written on accept of an in-range pixel, absolute difference times gain
  fdma_prev_store #(
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_prev (
    .clk      (clk),
    .adv      (adv),
    .we       (accept && in_rng),
    .addr     (in_addr),
    .pix      (in_gray_pixel),
    .gain     (diff_gain_r),
    .scaled_r (scaled)
  );

  // accumulator: read at accept, damp in stage 1, add and write in stage 2
  fdma_acc_store #(
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rd_addr (in_addr),
    .s1_ctl  (s1_ctl_r),
    .s1_addr (s1_addr_r),
    .s2_ctl  (s2_ctl_r),
    .s2_addr (s2_addr_r),
    .decay   (decay_factor_r),
    .scaled  (scaled),
    .level   (level)
  );

  // ---------------------------------------------------------------- output
  assign out_load = adv && s2_ctl_r.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // first frame and out-of-range pixels give an all-zero result
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ready_res_r <= s2_ctl_r.wr;
      out_motion_r    <= s2_ctl_r.wr && (level >= motion_level_r);
      out_level_r     <= s2_ctl_r.wr ? level : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ready_res = out_ready_res_r;
  assign out_motion    = out_motion_r;
  assign out_level     = out_level_r;

  // ---------------------------------------------------------------- checks
  // both update stages aiming at the same accumulator entry
  assign upd_overlap    = s1_ctl_r.vld && s1_ctl_r.wr && s2_ctl_r.vld && s2_ctl_r.wr &&
                          (s1_addr_r == s2_addr_r);
  assign out_blank      = out_valid && !out_ready_res;
  assign out_zero       = (out_level == '0) && !out_motion;
  assign out_ready_beat = out_valid && out_ready_res;
  assign phase_ready    = (frames_seen_r == PH_SECOND) || (frames_seen_r == PH_LATER);
  assign count_open     = frames_seen_r != PH_NONE;

  `FDMA_ASSERT(a_no_raw_overlap, !upd_overlap, "accumulator update overlaps the same entry")
  `FDMA_ASSERT_IMP(a_not_ready_zero, out_blank, out_zero, "result not ready but carries a value")
  `FDMA_ASSERT_IMP(a_ready_needs_frame, out_ready_beat, phase_ready, "ready before second frame")
  `FDMA_ASSERT_NXT(a_count_sticks, count_open, count_open, "frame count fell back to none")

endmodule
`default_nettype wire

// File: design/fdma_prev_store.sv
`default_nettype none
module fdma_prev_store import fdma_pkg::*; #(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
  localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1
) (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire logic                we,
  input  wire logic [ADDR_W-1:0]   addr,
  input  wire logic [PIX_W-1:0]    pix,
  input  wire logic [GAIN_W-1:0]   gain,
  output logic      [SCALED_W-1:0] scaled_r
);
  logic [PIX_W-1:0]    prev_mem [FRAME_PIXELS];
  logic [PIX_W-1:0]    prev_rd_r;
  logic [PIX_W-1:0]    pix_r;
  logic [PIX_W-1:0]    diff;
  logic [SCALED_W-1:0] scaled_nxt;

  // read-first: a write at the same address returns the old pixel
  always_ff @(posedge clk) begin
    if (adv) begin
      prev_rd_r <= prev_mem[addr];
      pix_r     <= pix;
    end
    if (we) begin
      prev_mem[addr] <= pix;
    end
  end

  always_comb begin
    diff       = (pix_r > prev_rd_r) ? (pix_r - prev_rd_r) : (prev_rd_r - pix_r);
    scaled_nxt = SCALED_W'(diff) * SCALED_W'(gain);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scaled_r <= scaled_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/fdma_acc_store.sv
`default_nettype none
module fdma_acc_store import fdma_pkg::*; #(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
  localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic [ADDR_W-1:0]   rd_addr,
  input  wire stage_ctl_t          s1_ctl,
  input  wire logic [ADDR_W-1:0]   s1_addr,
  input  wire stage_ctl_t          s2_ctl,
  input  wire logic [ADDR_W-1:0]   s2_addr,
  input  wire logic [DECAY_W-1:0]  decay,
  input  wire logic [SCALED_W-1:0] scaled,
  output logic      [LEVEL_W-1:0]  level
);
  logic [LEVEL_W-1:0] acc_mem [FRAME_PIXELS];
  logic [LEVEL_W-1:0] acc_rd_r;
  logic               wb_vld_r;
  logic [ADDR_W-1:0]  wb_addr_r;
  logic [LEVEL_W-1:0] wb_data_r;
  logic [LEVEL_W-1:0] acc_opnd;
  logic [DECAY_W-1:0] decay_eff;
  logic [PROD_W-1:0]  prod_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic [SUM_W-1:0]   base;
  logic [SUM_W-1:0]   sum;
  logic               s2_write;

  assign s2_write = adv && s2_ctl.vld && s2_ctl.wr;

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_rd_r <= acc_mem[rd_addr];
    end
    if (s2_write) begin
      acc_mem[s2_addr] <= level;
    end
  end

  // the write landing on the same edge as the read is missed by the memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
    end else if (adv) begin
      wb_vld_r <= s2_ctl.vld && s2_ctl.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wb_addr_r <= s2_addr;
      wb_data_r <= level;
    end
  end

  always_comb begin
    acc_opnd  = (wb_vld_r && (wb_addr_r == s1_addr)) ? wb_data_r : acc_rd_r;
    decay_eff = decay[DECAY_W-1] ? DECAY_ONE : decay;
    prod_nxt  = PROD_W'(acc_opnd) * PROD_W'(decay_eff) + DAMP_ROUND;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= s1_ctl.use_acc ? prod_nxt : '0;
    end
  end

  always_comb begin
    base  = SUM_W'(prod_r[PROD_W-1:DAMP_SHIFT]);
    sum   = base + SUM_W'(scaled);
    level = (sum > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : sum[LEVEL_W-1:0];
  end

endmodule
`default_nettype wire
